[rtl/trmi_pkg.sv]
`timescale 1ns / 1ps
package trmi_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CfgWidth  = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;
  localparam logic [1:0] CfgDark   = 2'd2;
  localparam logic [1:0] CfgPasses = 2'd3;

  // Reciprocal of three in 11 fractional bits; exact for sums up to 765.
  localparam logic [20:0] Recip3 = 21'd683;
  localparam int          Recip3Shift = 11;

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_PROC,
    PH_EMIT
  } trmi_phase_e;

  typedef enum logic [2:0] {
    ES_IDLE,
    ES_PREV,
    ES_CUR,
    ES_NEXT,
    ES_CALC
  } trmi_eng_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } trmi_eng_stat_t;

  // One channel of a 3-tap window: max, min or truncated average.
  function automatic logic [7:0] tap3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic blur,
                                      input logic dark);
    logic [7:0]  r;
    logic [9:0]  s;
    logic [20:0] m;
    r = a;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    m = 21'(s) * Recip3;
    if (blur) begin
      r = m[Recip3Shift +: 8];
    end else if (dark) begin
      if (b > r) r = b;
      if (c > r) r = c;
    end else begin
      if (b < r) r = b;
      if (c < r) r = c;
    end
    return r;
  endfunction

  function automatic logic [23:0] combine3(input logic [23:0] a, input logic [23:0] b,
                                           input logic [23:0] c, input logic blur,
                                           input logic dark);
    logic [23:0] o;
    for (int k = 0; k < 3; k++) begin
      o[8*k +: 8] = tap3(a[8*k +: 8], b[8*k +: 8], c[8*k +: 8], blur, dark);
    end
    return o;
  endfunction

endpackage

[rtl/trmi_in_if.sv]
`timescale 1ns / 1ps
interface trmi_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, op, red_in, green_in, blue_in, input ready);
  modport sink (input valid, op, red_in, green_in, blue_in, output ready);
endinterface

[rtl/trmi_out_if.sv]
`timescale 1ns / 1ps
interface trmi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       last;

  modport source (output valid, red_out, green_out, blue_out, last, input ready);
  modport sink (input valid, red_out, green_out, blue_out, last, output ready);
endinterface

[rtl/text_region_morph_inpaint_top.sv]
`timescale 1ns / 1ps
// Channel   Direction  Payload                                Transfer
// in_ch     in         op, red_in, green_in, blue_in          valid && ready
// out_ch    out        red_out, green_out, blue_out, last     valid && ready
// cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i        cfg_we_i high
//
// The transfer that completes the patch starts (2*passes + 2) sweeps over the W*H
// pixels; with the single read port of each store the engine reads a pixel's three
// taps in turn. A readout request passes the store read, then the output register.
// The stores are not cleared at reset; counters and phase are.
// in_ch stalls while processing, while a read is in flight, and while a result waits.
module text_region_morph_inpaint_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  trmi_in_if.sink    in_ch,
  trmi_out_if.source out_ch,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [8:0] cfg_data_i
);
  import trmi_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = AW + 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);

  logic [8:0] pw_q, ph_q;
  logic       dark_q;
  logic [2:0] pc_q;

  trmi_phase_e phase_q;
  logic [TW-1:0] load_cnt_q, emit_cnt_q;
  logic          start_q, rd_pend_q, last_pend_q;

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [2:0]    eff_p;
  logic [TW-1:0] total, load_idx, load_nxt;
  logic          in_xfer, load_xfer, emit_xfer;

  logic [AW-1:0] eng_raddr, eng_waddr, p_raddr, p_waddr;
  logic [23:0]   eng_wdata, p_wdata, p_rdata, s_rdata;
  logic          eng_pwe, eng_swe, p_we;
  trmi_eng_stat_t eng_stat;

  // Effective patch size and pass count.
  always_comb begin
    if (32'(pw_q) >= MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else if (pw_q < 9'd3)       eff_w = WW'(3);
    else                        eff_w = WW'(pw_q);
    if (32'(ph_q) >= MAX_HEIGHT) eff_h = HW'(MAX_HEIGHT);
    else if (ph_q < 9'd3)        eff_h = HW'(3);
    else                         eff_h = HW'(ph_q);
    eff_p = (pc_q == 3'd0) ? 3'd1 : pc_q;
  end

  assign total = TW'(eff_w) * TW'(eff_h);

  // Input handshake.
  assign in_ch.ready = (phase_q != PH_PROC) && !start_q && !rd_pend_q &&
                       !(out_ch.valid && !out_ch.ready);
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign load_xfer = in_xfer && !in_ch.op;
  assign emit_xfer = in_xfer && in_ch.op && (phase_q == PH_EMIT);
  assign load_idx  = (phase_q == PH_EMIT) ? '0 : load_cnt_q;
  assign load_nxt  = load_idx + TW'(1);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q   <= 9'd256;
      ph_q   <= 9'd256;
      dark_q <= 1'b1;
      pc_q   <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWidth:  pw_q   <= cfg_data_i;
        CfgHeight: ph_q   <= cfg_data_i;
        CfgDark:   dark_q <= cfg_data_i[0];
        CfgPasses: pc_q   <= cfg_data_i[2:0];
        default:   pw_q   <= pw_q;
      endcase
    end
  end

  // Phase and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LOAD;
      load_cnt_q  <= '0;
      emit_cnt_q  <= '0;
      start_q     <= 1'b0;
      rd_pend_q   <= 1'b0;
      last_pend_q <= 1'b0;
    end else begin
      start_q   <= 1'b0;
      rd_pend_q <= emit_xfer;
      if (cfg_we_i) begin
        phase_q    <= PH_LOAD;
        load_cnt_q <= '0;
        emit_cnt_q <= '0;
      end else if (load_xfer) begin
        emit_cnt_q <= '0;
        if (load_nxt >= total) begin
          phase_q    <= PH_PROC;
          load_cnt_q <= '0;
          start_q    <= 1'b1;
        end else begin
          phase_q    <= PH_LOAD;
          load_cnt_q <= load_nxt;
        end
      end else if (emit_xfer) begin
        last_pend_q <= (emit_cnt_q + TW'(1)) == total;
        if ((emit_cnt_q + TW'(1)) == total) begin
          phase_q    <= PH_LOAD;
          load_cnt_q <= '0;
          emit_cnt_q <= '0;
        end else begin
          emit_cnt_q <= emit_cnt_q + TW'(1);
        end
      end else if (eng_stat.done) begin
        phase_q    <= PH_EMIT;
        emit_cnt_q <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.valid <= 1'b0;
    end else if (rd_pend_q) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      out_ch.red_out   <= p_rdata[7:0];
      out_ch.green_out <= p_rdata[15:8];
      out_ch.blue_out  <= p_rdata[23:16];
      out_ch.last      <= last_pend_q;
    end
  end

  // Patch store port sharing between loader, readout and engine.
  assign p_raddr = eng_stat.busy ? eng_raddr : emit_cnt_q[AW-1:0];
  assign p_we    = eng_pwe || load_xfer;
  assign p_waddr = eng_stat.busy ? eng_waddr : load_idx[AW-1:0];
  assign p_wdata = eng_stat.busy ? eng_wdata
                                 : {in_ch.blue_in, in_ch.green_in, in_ch.red_in};

  trmi_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_patch (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  trmi_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_scratch (
    .clk_i   (clk_i),
    .we_i    (eng_swe),
    .waddr_i (eng_waddr),
    .wdata_i (eng_wdata),
    .raddr_i (eng_raddr),
    .rdata_o (s_rdata)
  );

  trmi_engine #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_q),
    .width_i       (eff_w),
    .height_i      (eff_h),
    .dark_i        (dark_q),
    .passes_i      (eff_p),
    .raddr_o       (eng_raddr),
    .patch_rdata_i (p_rdata),
    .scr_rdata_i   (s_rdata),
    .patch_we_o    (eng_pwe),
    .scr_we_o      (eng_swe),
    .waddr_o       (eng_waddr),
    .wdata_o       (eng_wdata),
    .stat_o        (eng_stat)
  );

  // Checks.
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_stat.busy |-> !in_ch.ready) else $error("input taken while processing");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |=> eng_stat.busy) else $error("engine did not start");
  a_read_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |=> out_ch.valid) else $error("readout lost");
  a_done_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_stat.done |=> phase_q == PH_EMIT) else $error("no readout after processing");

endmodule

[rtl/trmi_ram.sv]
`timescale 1ns / 1ps
module trmi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/trmi_engine.sv]
`timescale 1ns / 1ps
module trmi_engine #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]             width_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]            height_i,
  input  logic                                       dark_i,
  input  logic [2:0]                                 passes_i,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    raddr_o,
  input  logic [23:0]                                patch_rdata_i,
  input  logic [23:0]                                scr_rdata_i,
  output logic                                       patch_we_o,
  output logic                                       scr_we_o,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    waddr_o,
  output logic [23:0]                                wdata_o,
  output trmi_pkg::trmi_eng_stat_t                   stat_o
);
  import trmi_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  trmi_eng_state_e state_q, state_d;
  logic [WW-1:0] x_q;
  logic [HW-1:0] y_q;
  logic [AW-1:0] rb_q;
  logic [3:0]    sw_q;
  logic [23:0]   a_q, b_q;

  logic          vert, blur, x_end, y_end, sw_end;
  logic [AW-1:0] cur_addr, prev_addr, next_addr;
  logic [23:0]   rdata;

  // Sweep decode: even sweeps run along rows, odd ones along columns.
  assign vert   = sw_q[0];
  assign blur   = sw_q >= {passes_i, 1'b0};
  assign sw_end = sw_q == {passes_i, 1'b1};
  assign x_end  = x_q == width_i - WW'(1);
  assign y_end  = y_q == height_i - HW'(1);
  assign rdata  = vert ? scr_rdata_i : patch_rdata_i;

  // Window addresses with replicated edges.
  always_comb begin
    cur_addr = rb_q + AW'(x_q);
    if (vert) begin
      prev_addr = (y_q != '0) ? cur_addr - AW'(width_i) : cur_addr;
      next_addr = y_end ? cur_addr : cur_addr + AW'(width_i);
    end else begin
      prev_addr = (x_q != '0) ? cur_addr - AW'(1) : cur_addr;
      next_addr = x_end ? cur_addr : cur_addr + AW'(1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ES_IDLE: if (start_i) state_d = ES_PREV;
      ES_PREV: state_d = ES_CUR;
      ES_CUR:  state_d = ES_NEXT;
      ES_NEXT: state_d = ES_CALC;
      ES_CALC: state_d = (x_end && y_end && sw_end) ? ES_IDLE : ES_PREV;
      default: state_d = ES_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    raddr_o     = prev_addr;
    patch_we_o  = 1'b0;
    scr_we_o    = 1'b0;
    stat_o.busy = state_q != ES_IDLE;
    stat_o.done = 1'b0;
    unique case (state_q)
      ES_IDLE: raddr_o = prev_addr;
      ES_PREV: raddr_o = prev_addr;
      ES_CUR:  raddr_o = cur_addr;
      ES_NEXT: raddr_o = next_addr;
      ES_CALC: begin
        patch_we_o  = vert;
        scr_we_o    = !vert;
        stat_o.done = x_end && y_end && sw_end;
      end
      default: raddr_o = prev_addr;
    endcase
  end

  assign waddr_o = cur_addr;
  assign wdata_o = combine3(a_q, b_q, rdata, blur, dark_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ES_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Raster position and sweep counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q  <= '0;
      y_q  <= '0;
      rb_q <= '0;
      sw_q <= '0;
    end else if (state_q == ES_IDLE && start_i) begin
      x_q  <= '0;
      y_q  <= '0;
      rb_q <= '0;
      sw_q <= '0;
    end else if (state_q == ES_CALC) begin
      if (!x_end) begin
        x_q <= x_q + WW'(1);
      end else begin
        x_q <= '0;
        if (y_end) begin
          y_q  <= '0;
          rb_q <= '0;
          sw_q <= sw_q + 4'd1;
        end else begin
          y_q  <= y_q + HW'(1);
          rb_q <= rb_q + AW'(width_i);
        end
      end
    end
  end

  // Window samples arrive in the cycle after their read, from the registered store port.
  always_ff @(posedge clk_i) begin
    if (state_q == ES_CUR)  a_q <= rdata;
    if (state_q == ES_NEXT) b_q <= rdata;
  end

endmodule
